[rtl/sswp_pkg.sv]
package sswp_pkg;

    localparam int MAX_WINDOW = 16;
    localparam int K_W        = $clog2(MAX_WINDOW);
    localparam int FILL_W     = $clog2(MAX_WINDOW + 1);

    localparam int SAMPLE_W   = 32;
    localparam int IDX_W      = 16;
    localparam int CFG_W      = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int REM_W      = CFG_W;
    localparam int PROD_W     = 2 * SAMPLE_W;
    localparam int FRAC_W     = 16;

    localparam logic signed [SAMPLE_W-1:0] Q_ONE   = 32'sh0001_0000;
    localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [SAMPLE_W-1:0] SAT_MIN = 32'sh8000_0000;

    localparam logic [CFG_W-1:0] WINDOW_SIZE_RST = 5'd4;
    localparam logic [CFG_W-1:0] WINDOW_STEP_RST = 5'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW_SIZE = 2'd0,
        REG_WINDOW_STEP = 2'd1
    } sswp_reg_t;

    typedef struct packed {
        logic accept;
        logic load_out;
    } sswp_cmd_t;

    typedef struct packed {
        logic busy;
        logic emit;
        logic out_free;
    } sswp_stat_t;

endpackage

[rtl/sswp_ctrl.sv]
module sswp_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  sswp_pkg::sswp_stat_t stat,
    output sswp_pkg::sswp_cmd_t  cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;
    logic   finish;

    // window done: leave unless the result must wait for the output register
    assign finish = (state_reg == ST_RUN) && !stat.busy && (!stat.emit || stat.out_free);

    assign s_tready     = ready_reg;
    assign cmd.accept   = s_tvalid && ready_reg;
    assign cmd.load_out = finish && stat.emit;

    always_comb begin
        state_next = state_reg;
        ready_next = ready_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && ready_reg) begin
                    state_next = ST_RUN;
                    ready_next = 1'b0;
                end
            end
            ST_RUN: begin
                if (finish) begin
                    state_next = ST_IDLE;
                    ready_next = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
                ready_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
        end else begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> state_reg == ST_IDLE)
        else $error("ready raised outside idle");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> stat.out_free && !stat.busy)
        else $error("result loaded while output or units busy");

    a_accept_run: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept |=> state_reg == ST_RUN && stat.busy)
        else $error("accepted word did not start the units");

endmodule

[rtl/sswp_dp.sv]
module sswp_dp (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  sswp_pkg::sswp_cmd_t                  cmd,
    output sswp_pkg::sswp_stat_t                 stat,
    input  logic                                 cfg_valid,
    input  logic [sswp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [sswp_pkg::CFG_W-1:0]           cfg_data,
    input  logic signed [sswp_pkg::SAMPLE_W-1:0] sample,
    input  logic                                 last_sample,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [sswp_pkg::SAMPLE_W-1:0] out_product,
    output logic [sswp_pkg::IDX_W-1:0]           out_start,
    output logic                                 out_overflow
);

    // configuration
    logic [sswp_pkg::CFG_W-1:0] size_reg, size_next;
    logic [sswp_pkg::CFG_W-1:0] step_reg, step_next;

    // array tracking and window store
    logic signed [sswp_pkg::SAMPLE_W-1:0] store_reg [sswp_pkg::MAX_WINDOW];
    logic [sswp_pkg::IDX_W-1:0]  idx_reg, idx_next;
    logic [sswp_pkg::FILL_W-1:0] fill_reg, fill_next, fill_inc;
    logic [sswp_pkg::FILL_W-1:0] ws_eff;
    logic [sswp_pkg::CFG_W-1:0]  st_eff;
    logic [sswp_pkg::IDX_W-1:0]  start_calc;

    // per window
    logic [sswp_pkg::FILL_W-1:0] ws_reg;
    logic [sswp_pkg::CFG_W-1:0]  st_reg;
    logic [sswp_pkg::IDX_W-1:0]  start_reg;
    logic                        full_reg;

    // shared multiplier
    logic                                 mul_busy_reg, mul_busy_next;
    logic                                 phase_reg, phase_next;
    logic [sswp_pkg::K_W-1:0]             k_reg, k_next;
    logic signed [sswp_pkg::PROD_W-1:0]   prod_reg, prod_next;
    logic signed [sswp_pkg::SAMPLE_W-1:0] acc_reg, acc_next, acc_sat;
    logic                                 ovf_reg, ovf_next, sat_hit;
    logic [sswp_pkg::PROD_W-1:sswp_pkg::SAMPLE_W+sswp_pkg::FRAC_W-1] prod_hi;

    // stride remainder, one dividend bit a cycle
    logic                            mod_busy_reg, mod_busy_next;
    logic [sswp_pkg::IDX_W-1:0]      div_reg, div_next;
    logic [sswp_pkg::REM_W-1:0]      rem_reg, rem_next;
    logic [sswp_pkg::REM_W:0]        rem_trial;
    logic [$clog2(sswp_pkg::IDX_W)-1:0] bit_reg, bit_next;

    // output register
    logic                                 oval_reg, oval_next;
    logic signed [sswp_pkg::SAMPLE_W-1:0] oprod_reg;
    logic [sswp_pkg::IDX_W-1:0]           ostart_reg;
    logic                                 oovf_reg;

    always_comb begin
        if (size_reg == '0) begin
            ws_eff = sswp_pkg::FILL_W'(1);
        end else if (int'(size_reg) > sswp_pkg::MAX_WINDOW) begin
            ws_eff = sswp_pkg::FILL_W'(sswp_pkg::MAX_WINDOW);
        end else begin
            ws_eff = sswp_pkg::FILL_W'(size_reg);
        end
        st_eff     = (step_reg == '0) ? sswp_pkg::CFG_W'(1) : step_reg;
        start_calc = sswp_pkg::IDX_W'(idx_reg - sswp_pkg::IDX_W'(ws_eff)
                                      + sswp_pkg::IDX_W'(1));
        fill_inc   = (int'(fill_reg) < sswp_pkg::MAX_WINDOW) ?
                     sswp_pkg::FILL_W'(fill_reg + sswp_pkg::FILL_W'(1)) : fill_reg;
    end

    always_comb begin
        size_next = size_reg;
        step_next = step_reg;
        if (cfg_valid) begin
            case (cfg_index)
                sswp_pkg::REG_WINDOW_SIZE: size_next = cfg_data;
                sswp_pkg::REG_WINDOW_STEP: step_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        idx_next  = idx_reg;
        fill_next = fill_reg;
        if (cmd.accept) begin
            if (last_sample) begin
                idx_next  = '0;
                fill_next = '0;
            end else begin
                idx_next  = sswp_pkg::IDX_W'(idx_reg + sswp_pkg::IDX_W'(1));
                fill_next = fill_inc;
            end
        end
    end

    // multiply, then floor by 2^16 and saturate; a register between the two
    always_comb begin
        prod_hi = prod_reg[sswp_pkg::PROD_W-1:sswp_pkg::SAMPLE_W+sswp_pkg::FRAC_W-1];
        sat_hit = !((&prod_hi) || !(|prod_hi));
        if (!sat_hit) begin
            acc_sat = prod_reg[sswp_pkg::SAMPLE_W+sswp_pkg::FRAC_W-1:sswp_pkg::FRAC_W];
        end else if (prod_reg[sswp_pkg::PROD_W-1]) begin
            acc_sat = sswp_pkg::SAT_MIN;
        end else begin
            acc_sat = sswp_pkg::SAT_MAX;
        end

        mul_busy_next = mul_busy_reg;
        phase_next    = phase_reg;
        k_next        = k_reg;
        prod_next     = prod_reg;
        acc_next      = acc_reg;
        ovf_next      = ovf_reg;
        if (cmd.accept) begin
            mul_busy_next = 1'b1;
            phase_next    = 1'b0;
            k_next        = sswp_pkg::K_W'(ws_eff - sswp_pkg::FILL_W'(1));
            acc_next      = sswp_pkg::Q_ONE;
            ovf_next      = 1'b0;
        end else if (mul_busy_reg) begin
            if (!phase_reg) begin
                prod_next  = acc_reg * store_reg[k_reg];
                phase_next = 1'b1;
            end else begin
                acc_next   = acc_sat;
                ovf_next   = ovf_reg || sat_hit;
                phase_next = 1'b0;
                if (k_reg == '0) begin
                    mul_busy_next = 1'b0;
                end else begin
                    k_next = k_reg - sswp_pkg::K_W'(1);
                end
            end
        end
    end

    always_comb begin
        rem_trial     = {rem_reg, div_reg[sswp_pkg::IDX_W-1]};
        mod_busy_next = mod_busy_reg;
        div_next      = div_reg;
        rem_next      = rem_reg;
        bit_next      = bit_reg;
        if (cmd.accept) begin
            mod_busy_next = 1'b1;
            div_next      = start_calc;
            rem_next      = '0;
            bit_next      = '0;
        end else if (mod_busy_reg) begin
            if (rem_trial >= {1'b0, st_reg}) begin
                rem_next = sswp_pkg::REM_W'(rem_trial - {1'b0, st_reg});
            end else begin
                rem_next = sswp_pkg::REM_W'(rem_trial);
            end
            div_next = {div_reg[sswp_pkg::IDX_W-2:0], 1'b0};
            bit_next = bit_reg + 1'b1;
            if (&bit_reg) begin
                mod_busy_next = 1'b0;
            end
        end
    end

    always_comb begin
        oval_next = oval_reg;
        if (cmd.load_out) begin
            oval_next = 1'b1;
        end else if (out_ready) begin
            oval_next = 1'b0;
        end
    end

    assign stat.busy     = mul_busy_reg || mod_busy_reg;
    assign stat.emit     = full_reg && (rem_reg == '0);
    assign stat.out_free = !oval_reg || out_ready;

    assign out_valid    = oval_reg;
    assign out_product  = oprod_reg;
    assign out_start    = ostart_reg;
    assign out_overflow = oovf_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg     <= sswp_pkg::WINDOW_SIZE_RST;
            step_reg     <= sswp_pkg::WINDOW_STEP_RST;
            idx_reg      <= '0;
            fill_reg     <= '0;
            mul_busy_reg <= 1'b0;
            mod_busy_reg <= 1'b0;
            oval_reg     <= 1'b0;
        end else begin
            size_reg     <= size_next;
            step_reg     <= step_next;
            idx_reg      <= idx_next;
            fill_reg     <= fill_next;
            mul_busy_reg <= mul_busy_next;
            mod_busy_reg <= mod_busy_next;
            oval_reg     <= oval_next;
        end
    end

    always_ff @(posedge aclk) begin
        phase_reg <= phase_next;
        k_reg     <= k_next;
        prod_reg  <= prod_next;
        acc_reg   <= acc_next;
        ovf_reg   <= ovf_next;
        div_reg   <= div_next;
        rem_reg   <= rem_next;
        bit_reg   <= bit_next;
        if (cmd.accept) begin
            store_reg[0] <= sample;
            for (int i = 1; i < sswp_pkg::MAX_WINDOW; i++) begin
                store_reg[i] <= store_reg[i-1];
            end
            ws_reg    <= ws_eff;
            st_reg    <= st_eff;
            start_reg <= start_calc;
            full_reg  <= (fill_inc >= ws_eff);
        end
        if (cmd.load_out) begin
            oprod_reg  <= acc_reg;
            ostart_reg <= start_reg;
            oovf_reg   <= ovf_reg;
        end
    end

    a_rem_below_step: assert property (@(posedge aclk) disable iff (!aresetn)
        mod_busy_reg |-> rem_reg < st_reg)
        else $error("remainder reached the stride");

    a_tap_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_busy_reg |-> int'(k_reg) < int'(ws_reg))
        else $error("multiplier tap outside the window");

    a_out_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && !out_ready |=> out_valid && $stable(out_product)
                                    && $stable(out_start))
        else $error("pending result changed");

endmodule

[rtl/strided_sliding_window_product_top.sv]
// From an accepted word to its result, if any, on m_tvalid, the 16-step stride remainder and
// the shared multiplier (multiply, then floor and saturate, for each sample) run side by side;
// the result then goes through the output register.
// s_tready stays low until both units are done and any result is loaded, also while a result waits.
// Reset: synchronous, active-low aresetn; window_size 4, window_step 2, index and fill zero.
module strided_sliding_window_product_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] sample
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [31:0] window_product, [47:32] window_start
    output logic        m_tuser,   // [0] overflow
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [sswp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sswp_pkg::CFG_W-1:0]     cfg_data
);

    sswp_pkg::sswp_cmd_t  cmd;
    sswp_pkg::sswp_stat_t stat;
    logic signed [sswp_pkg::SAMPLE_W-1:0] product;
    logic [sswp_pkg::IDX_W-1:0]           start;

    assign cfg_ready = 1'b1;
    assign m_tdata   = {start, product};

    sswp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sswp_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample       ($signed(s_tdata)),
        .last_sample  (s_tlast),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_product  (product),
        .out_start    (start),
        .out_overflow (m_tuser)
    );

endmodule

[verif/tb_strided_sliding_window_product_top.sv]
module tb_strided_sliding_window_product_top;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE_CYCLES = 40;    // above the worst input-to-result latency
    localparam int PHASE_SAMPLES = 100;

    typedef struct {
        logic [31:0] product;
        logic [15:0] first_idx;
        logic        ovf;
    } window_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [sswp_pkg::CFG_IDX_W-1:0] cfg_index = sswp_pkg::REG_WINDOW_SIZE;
    logic [sswp_pkg::CFG_W-1:0]     cfg_data = '0;

    // predictor state
    logic signed [31:0] win_store [sswp_pkg::MAX_WINDOW];
    logic [15:0] next_index;
    int          fill_count;
    logic [sswp_pkg::CFG_W-1:0] size_reg;
    logic [sswp_pkg::CFG_W-1:0] step_reg;
    window_t     expected_windows [$];

    int  mismatch_count = 0;
    int  cycle_count = 0;
    int  ready_hold = 0;
    bit  in_gaps = 1'b0;
    bit  out_gaps = 1'b0;
    int  array_left = 0;

    strided_sliding_window_product_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // result-side back-pressure
    always @(posedge aclk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else if (out_gaps && $urandom_range(0, 5) == 0) begin
            m_tready   <= 1'b0;
            ready_hold <= $urandom_range(1, 15);
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < 50)
            $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin
        window_t w;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_windows.size() == 0) begin
                report_mismatch("unexpected word", m_tdata[31:0], '0);
            end else begin
                w = expected_windows.pop_front();
                if (m_tdata[31:0] !== w.product)
                    report_mismatch("window_product", m_tdata[31:0], w.product);
                if (m_tdata[47:32] !== w.first_idx)
                    report_mismatch("window_start", 32'(m_tdata[47:32]), 32'(w.first_idx));
                if (m_tuser !== w.ovf)
                    report_mismatch("overflow", 32'(m_tuser), 32'(w.ovf));
            end
        end
    end

    task automatic predict_window(input logic [31:0] smp, input logic lst);
        int      ws;
        int      stp;
        int      k;
        logic [15:0] first_idx;
        longint  acc;
        longint  p;
        logic    sat;
        window_t w;
        for (k = sswp_pkg::MAX_WINDOW - 1; k > 0; k--)
            win_store[k] = win_store[k-1];
        win_store[0] = smp;
        if (fill_count < sswp_pkg::MAX_WINDOW)
            fill_count++;
        ws = size_reg;
        if (ws == 0)
            ws = 1;
        if (ws > sswp_pkg::MAX_WINDOW)
            ws = sswp_pkg::MAX_WINDOW;
        stp = step_reg;
        if (stp == 0)
            stp = 1;
        first_idx = next_index - 16'(ws) + 16'd1;
        if (fill_count >= ws && int'(first_idx) % stp == 0) begin
            acc = longint'(sswp_pkg::Q_ONE);
            sat = 1'b0;
            for (k = ws - 1; k >= 0; k--) begin
                p = (acc * longint'(win_store[k])) >>> sswp_pkg::FRAC_W;
                if (p > longint'(sswp_pkg::SAT_MAX)) begin
                    p = longint'(sswp_pkg::SAT_MAX);
                    sat = 1'b1;
                end else if (p < longint'(sswp_pkg::SAT_MIN)) begin
                    p = longint'(sswp_pkg::SAT_MIN);
                    sat = 1'b1;
                end
                acc = p;
            end
            w.product = acc[31:0];
            w.first_idx = first_idx;
            w.ovf = sat;
            expected_windows.push_back(w);
        end
        next_index = next_index + 16'd1;
        if (lst) begin
            next_index = '0;
            fill_count = 0;
        end
    endtask

    task automatic send_sample(input logic [31:0] smp, input logic lst);
        if (in_gaps && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tlast  <= lst;
        do @(posedge aclk); while (!s_tready);
        predict_window(smp, lst);
    endtask

    task automatic write_reg(input sswp_pkg::sswp_reg_t idx,
                             input logic [sswp_pkg::CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == sswp_pkg::REG_WINDOW_SIZE)
            size_reg = val;
        else
            step_reg = val;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // hold off input until every pending window is out, then let the pipe settle
    task automatic drain_windows();
        s_tvalid <= 1'b0;
        while (expected_windows.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_sample();
        logic [31:0] v;
        case ($urandom_range(0, 7))
            0, 1: v = $urandom;
            2, 3: v = sswp_pkg::Q_ONE + 32'($urandom_range(0, 8191)) - 32'd4096;
            4:    v = -(sswp_pkg::Q_ONE + 32'($urandom_range(0, 8191)) - 32'd4096);
            5:    v = 32'($urandom_range(0, 131071)) - 32'd65536;
            6: begin
                case ($urandom_range(0, 5))
                    0: v = sswp_pkg::SAT_MAX;
                    1: v = sswp_pkg::SAT_MIN;
                    2: v = 32'hFFFF_FFFF;
                    3: v = 32'd1;
                    4: v = '0;
                    default: v = sswp_pkg::Q_ONE;
                endcase
            end
            default: v = {$urandom_range(0, 1) ? 8'h00 : 8'hFF, 24'($urandom)};
        endcase
        return v;
    endfunction

    function automatic logic take_last();
        if (array_left == 0) begin
            if ($urandom_range(0, 4) == 0)
                array_left = $urandom_range(1, 3);
            else
                array_left = $urandom_range(4, 40);
        end
        array_left--;
        return array_left == 0;
    endfunction

    task automatic test_directed_extremes();
        logic [31:0] vals [20];
        logic        lasts [20];
        int i;
        vals = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'hFFFF_0000, 32'h0001_0000, 32'h8000_0000, 32'h8000_0000,
                 32'hFFFF_FFFF, 32'h0000_8000, 32'h0000_0000, 32'h0000_0001,
                 32'h1234_5678,
                 32'hFFFF_FFFF, 32'h0000_8000, 32'h0001_0000, 32'h0000_0001,
                 32'h0001_8000, 32'hFFFE_8000, 32'h0000_4000};
        lasts = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                  1'b0, 1'b1,
                  1'b1,
                  1'b0, 1'b0, 1'b0, 1'b1,
                  1'b0, 1'b0, 1'b0};
        in_gaps = 1'b0;
        out_gaps = 1'b0;
        for (i = 0; i < 20; i++)
            send_sample(vals[i], lasts[i]);
        drain_windows();
    endtask

    task automatic test_config_sweep();
        logic [sswp_pkg::CFG_W-1:0] sizes [12];
        logic [sswp_pkg::CFG_W-1:0] steps [12];
        int ph;
        int n;
        sizes = '{5'd0, 5'd31, 5'd16, 5'd1, 5'd1, 5'd16, 5'd17, 5'd2, 5'd8, 5'd3, 5'd0, 5'd0};
        steps = '{5'd0, 5'd31, 5'd16, 5'd17, 5'd1, 5'd1, 5'd5, 5'd3, 5'd0, 5'd2, 5'd0, 5'd0};
        sizes[10] = 5'($urandom_range(1, 16));
        steps[10] = 5'($urandom_range(1, 16));
        sizes[11] = 5'($urandom_range(0, 31));
        steps[11] = 5'($urandom_range(0, 31));
        for (ph = 0; ph < 12; ph++) begin
            write_reg(sswp_pkg::REG_WINDOW_SIZE, sizes[ph]);
            write_reg(sswp_pkg::REG_WINDOW_STEP, steps[ph]);
            in_gaps = $urandom_range(0, 3) != 0;
            out_gaps = $urandom_range(0, 3) != 0;
            for (n = 0; n < PHASE_SAMPLES; n++) begin
                if (n == PHASE_SAMPLES / 2) begin
                    in_gaps = !in_gaps;
                    out_gaps = !out_gaps;
                end
                send_sample(rand_sample(), take_last());
            end
            // config change may land mid-array
            drain_windows();
        end
    endtask

    task automatic test_final_burst();
        int n;
        write_reg(sswp_pkg::REG_WINDOW_SIZE, 5'd5);
        write_reg(sswp_pkg::REG_WINDOW_STEP, 5'd1);
        in_gaps = 1'b0;
        out_gaps = 1'b0;
        for (n = 0; n < 150; n++)
            send_sample(rand_sample(), take_last());
        drain_windows();
    endtask

    initial begin
        int i;
        for (i = 0; i < sswp_pkg::MAX_WINDOW; i++)
            win_store[i] = '0;
        next_index = '0;
        fill_count = 0;
        size_reg = sswp_pkg::WINDOW_SIZE_RST;
        step_reg = sswp_pkg::WINDOW_STEP_RST;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_extremes();
        test_config_sweep();
        test_final_burst();

        if (mismatch_count == 0 && expected_windows.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            if (expected_windows.size() != 0)
                report_mismatch("words never seen", 32'(expected_windows.size()), '0);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[strided_sliding_window_product_top.f]
rtl/sswp_pkg.sv
rtl/sswp_ctrl.sv
rtl/sswp_dp.sv
rtl/strided_sliding_window_product_top.sv
verif/tb_strided_sliding_window_product_top.sv
